[rtl/core/kps_pkg.sv]
package kps_pkg;

   localparam int KEYFRAME_SLOTS     = 64;
   localparam int TIME_FRACTION_BITS = 16;

   localparam int IDX_W       = $clog2(KEYFRAME_SLOTS);
   localparam int WALK_CNT_W  = $clog2(KEYFRAME_SLOTS + 1);
   localparam int PARAM_SHIFT = 2 * TIME_FRACTION_BITS - 16;

   localparam int DT_W        = 16;
   localparam int RATE_W      = 16;
   localparam int RATE_FRAC   = 8;
   localparam int STEP_PROD_W = DT_W + 1 + RATE_W;
   localparam int STEP_W      = STEP_PROD_W - RATE_FRAC;

   localparam int KT_W       = 40;
   localparam int CLIP_W     = 48;
   localparam int DIV_CNT_W  = $clog2(KT_W);

   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 32;

   localparam logic [CSR_IDX_W-1:0] CSR_PLAYBACK_RATE   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FIRST_INDEX     = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_FINAL_INDEX     = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_DIRECTION       = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_CLIP_DUR_INVERSE = 3'd4;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SCALE,
      ST_ACCUM,
      ST_FWD_WAIT,
      ST_FWD_EVAL,
      ST_BWD_CHECK,
      ST_BWD_WAIT,
      ST_BWD_ADD,
      ST_DIV,
      ST_KP_WAIT,
      ST_MUL_KP,
      ST_MUL_LO,
      ST_MUL_HI,
      ST_CLIP
   } kps_state_type;

endpackage

[rtl/core/keyframe_playback_sequencer_unit.sv]
// Channel   Handshake                 Beat carries
// req       start / busy              mode, dt, entry_index, entry_duration, entry_inverse
// rsp       rsp_valid (one cycle)     keyframe_index, keyframe_param, clip_param
// csr       csr_valid / csr_ready     csr_index, csr_data
//
// A table write beat is stored at its accept edge and busy stays low.
// A tick walks the keyframe table, then computes the keyframe and clip parameters; the
// walk time grows with each forward or backward keyframe step and with the one
// remainder pass that skips whole clip loops. A tick walks only one way, and the table
// memory read in every walk step sets the cost of each step.
// Reset is synchronous and clears the FSM, clip state and CSRs, not the table.
// The result strobe lasts one cycle and cannot be stalled.
module keyframe_playback_sequencer_unit (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic                                req_mode,
   input  logic [kps_pkg::DT_W-1:0]            req_dt,
   input  logic [5:0]                          req_entry_index,
   input  logic [31:0]                         req_entry_duration,
   input  logic [31:0]                         req_entry_duration_inverse,
   output logic                                rsp_valid,
   output logic [5:0]                          rsp_keyframe_index,
   output logic [15:0]                         rsp_keyframe_param,
   output logic signed [31:0]                  rsp_clip_param,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [kps_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [kps_pkg::CSR_DATA_W-1:0]      csr_data
);
   import kps_pkg::*;

   localparam logic [63:0] LOST_MASK = (64'd1 << PARAM_SHIFT) - 64'd1;
   localparam logic signed [CLIP_W-1:0] CLIP_MAX = {1'b0, {(CLIP_W-1){1'b1}}};
   localparam logic signed [CLIP_W-1:0] CLIP_MIN = {1'b1, {(CLIP_W-1){1'b0}}};

   // Configuration registers.
   logic signed [RATE_W-1:0] rate_ff;
   logic [IDX_W-1:0]         first_ff;
   logic [IDX_W-1:0]         final_ff;
   logic signed [1:0]        dir_ff;
   logic [31:0]              cdi_ff;

   // Table memory: inverse in the upper word, duration in the lower word.
   logic [63:0] tbl_mem [KEYFRAME_SLOTS];
   logic [63:0] tbl_rd_ff;

   kps_state_type state_ff, state_in;

   logic [IDX_W-1:0]         idx_ff, idx_in;
   logic signed [KT_W-1:0]   kt_ff, kt_in;
   logic signed [CLIP_W-1:0] clip_ff, clip_in;

   logic                     anc_vld_ff, anc_vld_in;
   logic [IDX_W-1:0]         anc_idx_ff, anc_idx_in;
   logic signed [KT_W-1:0]   anc_t_ff, anc_t_in;
   logic                     reduced_ff, reduced_in;
   logic [WALK_CNT_W-1:0]    walk_cnt_ff, walk_cnt_in;

   logic [KT_W:0]            div_rem_ff, div_rem_in;
   logic [KT_W-1:0]          div_dvd_ff, div_dvd_in;
   logic [KT_W-1:0]          div_dvs_ff, div_dvs_in;
   logic [DIV_CNT_W-1:0]     div_cnt_ff, div_cnt_in;
   logic                     div_neg_ff, div_neg_in;

   logic [DT_W-1:0]               dt_ff, dt_in;
   logic signed [STEP_PROD_W-1:0] stp_prod_ff, stp_prod_in;
   logic [63:0]                   prod_ff, prod_in;
   logic [63:0]                   p0_ff, p0_in;
   logic [15:0]                   kp_ff, kp_in;

   logic                     rsp_valid_ff, rsp_valid_in;
   logic [IDX_W-1:0]         rsp_idx_ff, rsp_idx_in;
   logic [15:0]              rsp_kp_ff, rsp_kp_in;
   logic [31:0]              rsp_cp_ff, rsp_cp_in;

   logic                          accept;
   logic [31:0]                   dur_raw;
   logic signed [KT_W-1:0]        dur;
   logic [IDX_W-1:0]              dir_ext;
   logic [IDX_W-1:0]              idx_fwd;
   logic [IDX_W-1:0]              idx_bwd;
   logic                          walk_cap;
   logic                          revisit;
   logic signed [STEP_PROD_W-1:0] stp_prod;
   logic signed [STEP_W-1:0]      stp;
   logic signed [CLIP_W:0]        clip_sum;
   logic [CLIP_W-1:0]             clip_abs;
   logic [KT_W:0]                 rem_shift;
   logic [KT_W:0]                 rem_next;
   logic [31:0]                   mul_x;
   logic [31:0]                   mul_y;
   logic [63:0]                   mul_prod;
   logic [63:0]                   kp_shift;
   logic [63:0]                   clip_mag;
   logic [63:0]                   clip_mag_adj;
   logic                          clip_neg;
   logic                          clip_lost;
   logic                          clip_sat;
   logic [31:0]                   clip_res;

   assign accept    = start && (state_ff == ST_IDLE);
   assign busy      = (state_ff != ST_IDLE);
   assign csr_ready = 1'b1;

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_keyframe_index = 6'(rsp_idx_ff);
   assign rsp_keyframe_param = rsp_kp_ff;
   assign rsp_clip_param     = $signed(rsp_cp_ff);

   // A stored duration of zero reads as one time unit.
   assign dur_raw = tbl_rd_ff[31:0];
   assign dur     = $signed({{(KT_W-32){1'b0}}, (dur_raw == 32'd0) ? 32'd1 : dur_raw});

   assign dir_ext = {{(IDX_W-2){dir_ff[1]}}, dir_ff};
   assign idx_fwd = (idx_ff == final_ff) ? first_ff : idx_ff + dir_ext;
   assign idx_bwd = (idx_ff == first_ff) ? final_ff : idx_ff - dir_ext;

   // After as many steps as there are slots the walk is surely inside its cycle,
   // so that keyframe is the anchor; coming back to it gives the loop length.
   assign walk_cap = (walk_cnt_ff == WALK_CNT_W'(KEYFRAME_SLOTS));
   assign revisit  = anc_vld_ff && !reduced_ff && (idx_ff == anc_idx_ff);

   assign stp_prod = $signed({1'b0, dt_ff}) * rate_ff;
   assign stp      = $signed(stp_prod_ff[STEP_PROD_W-1:RATE_FRAC]);
   assign clip_sum = {clip_ff[CLIP_W-1], clip_ff} + {{(CLIP_W+1-STEP_W){stp[STEP_W-1]}}, stp};
   assign clip_abs = clip_ff[CLIP_W-1] ? CLIP_W'(-clip_ff) : CLIP_W'(clip_ff);

   assign rem_shift = {div_rem_ff[KT_W-1:0], div_dvd_ff[KT_W-1]};
   assign rem_next  = (rem_shift >= {1'b0, div_dvs_ff}) ? rem_shift - {1'b0, div_dvs_ff}
                                                       : rem_shift;

   // One shared 32 by 32 multiplier for the keyframe and clip parameters.
   always_comb begin
      unique case (state_ff)
         ST_MUL_KP: begin
            mul_x = kt_ff[31:0];
            mul_y = tbl_rd_ff[63:32];
         end
         ST_MUL_LO: begin
            mul_x = clip_abs[31:0];
            mul_y = cdi_ff;
         end
         default: begin
            mul_x = 32'(clip_abs[CLIP_W-1:32]);
            mul_y = cdi_ff;
         end
      endcase
   end
   assign mul_prod = {32'd0, mul_x} * {32'd0, mul_y};

   assign kp_shift = prod_ff >> PARAM_SHIFT;

   // The clip multiply's high part is in prod_ff, the low part in p0_ff.
   assign clip_neg     = clip_ff[CLIP_W-1];
   assign clip_sat     = (prod_ff >= 64'h0000_0000_8000_0000);
   assign clip_mag     = (prod_ff << (32 - PARAM_SHIFT)) + (p0_ff >> PARAM_SHIFT);
   assign clip_lost    = ((p0_ff & LOST_MASK) != 64'd0);
   assign clip_mag_adj = clip_mag + {63'd0, clip_lost};

   always_comb begin
      if (clip_sat) begin
         clip_res = clip_neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
      end else if (clip_neg) begin
         clip_res = (clip_mag_adj >= 64'h0000_0000_8000_0000) ? 32'h8000_0000
                                                              : 32'd0 - clip_mag_adj[31:0];
      end else begin
         clip_res = (clip_mag > 64'h0000_0000_7FFF_FFFF) ? 32'h7FFF_FFFF : clip_mag[31:0];
      end
   end

   always_comb begin
      state_in     = state_ff;
      idx_in       = idx_ff;
      kt_in        = kt_ff;
      clip_in      = clip_ff;
      anc_vld_in   = anc_vld_ff;
      anc_idx_in   = anc_idx_ff;
      anc_t_in     = anc_t_ff;
      reduced_in   = reduced_ff;
      walk_cnt_in  = walk_cnt_ff;
      div_rem_in   = div_rem_ff;
      div_dvd_in   = div_dvd_ff;
      div_dvs_in   = div_dvs_ff;
      div_cnt_in   = div_cnt_ff;
      div_neg_in   = div_neg_ff;
      dt_in        = dt_ff;
      stp_prod_in  = stp_prod_ff;
      prod_in      = prod_ff;
      p0_in        = p0_ff;
      kp_in        = kp_ff;
      rsp_valid_in = 1'b0;
      rsp_idx_in   = rsp_idx_ff;
      rsp_kp_in    = rsp_kp_ff;
      rsp_cp_in    = rsp_cp_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept && !req_mode) begin
               dt_in    = req_dt;
               state_in = ST_SCALE;
            end
         end
         ST_SCALE: begin
            stp_prod_in = stp_prod;
            state_in    = ST_ACCUM;
         end
         ST_ACCUM: begin
            if (clip_sum[CLIP_W] != clip_sum[CLIP_W-1]) begin
               clip_in = clip_sum[CLIP_W] ? CLIP_MIN : CLIP_MAX;
            end else begin
               clip_in = clip_sum[CLIP_W-1:0];
            end
            kt_in       = kt_ff + {{(KT_W-STEP_W){stp[STEP_W-1]}}, stp};
            anc_vld_in  = 1'b0;
            reduced_in  = 1'b0;
            walk_cnt_in = '0;
            state_in    = ST_FWD_WAIT;
         end
         ST_FWD_WAIT: begin
            state_in = ST_FWD_EVAL;
         end
         ST_FWD_EVAL: begin
            if (kt_ff < dur) begin
               anc_vld_in  = 1'b0;
               reduced_in  = 1'b0;
               walk_cnt_in = '0;
               state_in    = ST_BWD_CHECK;
            end else if (revisit) begin
               div_dvd_in = kt_ff;
               div_dvs_in = anc_t_ff - kt_ff;
               div_rem_in = '0;
               div_cnt_in = '0;
               div_neg_in = 1'b0;
               state_in   = ST_DIV;
            end else begin
               if (walk_cap && !anc_vld_ff) begin
                  anc_vld_in = 1'b1;
                  anc_idx_in = idx_ff;
                  anc_t_in   = kt_ff;
               end
               if (!walk_cap) begin
                  walk_cnt_in = walk_cnt_ff + 1'b1;
               end
               kt_in    = kt_ff - dur;
               idx_in   = idx_fwd;
               state_in = ST_FWD_WAIT;
            end
         end
         ST_BWD_CHECK: begin
            if (!kt_ff[KT_W-1]) begin
               state_in = ST_KP_WAIT;
            end else if (revisit) begin
               div_dvd_in = -kt_ff;
               div_dvs_in = kt_ff - anc_t_ff;
               div_rem_in = '0;
               div_cnt_in = '0;
               div_neg_in = 1'b1;
               state_in   = ST_DIV;
            end else begin
               if (walk_cap && !anc_vld_ff) begin
                  anc_vld_in = 1'b1;
                  anc_idx_in = idx_ff;
                  anc_t_in   = kt_ff;
               end
               if (!walk_cap) begin
                  walk_cnt_in = walk_cnt_ff + 1'b1;
               end
               idx_in   = idx_bwd;
               state_in = ST_BWD_WAIT;
            end
         end
         ST_BWD_WAIT: begin
            state_in = ST_BWD_ADD;
         end
         ST_BWD_ADD: begin
            kt_in    = kt_ff + dur;
            state_in = ST_BWD_CHECK;
         end
         ST_DIV: begin
            // Restoring remainder, one quotient bit per cycle.
            div_rem_in = rem_next;
            div_dvd_in = {div_dvd_ff[KT_W-2:0], 1'b0};
            div_cnt_in = div_cnt_ff + 1'b1;
            if (div_cnt_ff == DIV_CNT_W'(KT_W - 1)) begin
               reduced_in = 1'b1;
               if (div_neg_ff) begin
                  kt_in    = -$signed(rem_next[KT_W-1:0]);
                  state_in = ST_BWD_CHECK;
               end else begin
                  kt_in    = $signed(rem_next[KT_W-1:0]);
                  state_in = ST_FWD_WAIT;
               end
            end
         end
         ST_KP_WAIT: begin
            state_in = ST_MUL_KP;
         end
         ST_MUL_KP: begin
            prod_in  = mul_prod;
            state_in = ST_MUL_LO;
         end
         ST_MUL_LO: begin
            kp_in    = (kp_shift > 64'h0000_0000_0000_FFFF) ? 16'hFFFF : kp_shift[15:0];
            prod_in  = mul_prod;
            state_in = ST_MUL_HI;
         end
         ST_MUL_HI: begin
            p0_in    = prod_ff;
            prod_in  = mul_prod;
            state_in = ST_CLIP;
         end
         ST_CLIP: begin
            rsp_valid_in = 1'b1;
            rsp_idx_in   = idx_ff;
            rsp_kp_in    = kp_ff;
            rsp_cp_in    = clip_res;
            state_in     = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         idx_ff       <= '0;
         kt_ff        <= '0;
         clip_ff      <= '0;
         anc_vld_ff   <= 1'b0;
         reduced_ff   <= 1'b0;
         walk_cnt_ff  <= '0;
         rsp_valid_ff <= 1'b0;
         rate_ff      <= RATE_W'(256);
         first_ff     <= '0;
         final_ff     <= '0;
         dir_ff       <= 2'sd1;
         cdi_ff       <= 32'(64'd1 << TIME_FRACTION_BITS);
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         kt_ff        <= kt_in;
         clip_ff      <= clip_in;
         anc_vld_ff   <= anc_vld_in;
         reduced_ff   <= reduced_in;
         walk_cnt_ff  <= walk_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_PLAYBACK_RATE:    rate_ff  <= $signed(csr_data[RATE_W-1:0]);
               CSR_FIRST_INDEX:      first_ff <= csr_data[IDX_W-1:0];
               CSR_FINAL_INDEX:      final_ff <= csr_data[IDX_W-1:0];
               CSR_DIRECTION:        dir_ff   <= $signed(csr_data[1:0]);
               CSR_CLIP_DUR_INVERSE: cdi_ff   <= csr_data[31:0];
               default: begin
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      anc_idx_ff  <= anc_idx_in;
      anc_t_ff    <= anc_t_in;
      div_rem_ff  <= div_rem_in;
      div_dvd_ff  <= div_dvd_in;
      div_dvs_ff  <= div_dvs_in;
      div_cnt_ff  <= div_cnt_in;
      div_neg_ff  <= div_neg_in;
      dt_ff       <= dt_in;
      stp_prod_ff <= stp_prod_in;
      prod_ff     <= prod_in;
      p0_ff       <= p0_in;
      kp_ff       <= kp_in;
      rsp_idx_ff  <= rsp_idx_in;
      rsp_kp_ff   <= rsp_kp_in;
      rsp_cp_ff   <= rsp_cp_in;
   end

   // The table is read at the current keyframe every cycle; a write beat lands
   // at its accept edge.
   always_ff @(posedge clock) begin
      if (accept && req_mode) begin
         tbl_mem[req_entry_index[IDX_W-1:0]] <= {req_entry_duration_inverse,
                                                 req_entry_duration};
      end
      tbl_rd_ff <= tbl_mem[idx_ff];
   end

endmodule

[rtl/core/kps_checker.sv]
module kps_checker (
   input logic clock,
   input logic reset,
   input logic start,
   input logic busy,
   input logic req_mode,
   input logic rsp_valid
);

   // The result strobe never lasts more than one cycle.
   a_strobe_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("rsp_valid held for more than one cycle");

   // An accepted tick keeps the block busy in the next cycle.
   a_tick_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && !req_mode) |=> busy)
      else $error("tick beat accepted but block not busy");

   // A table write beat completes without raising busy.
   a_write_idle: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_mode) |=> !busy)
      else $error("table write beat made the block busy");

   // Busy ends only with a delivered result.
   a_busy_end: assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && $fell(busy)) |-> rsp_valid)
      else $error("busy dropped without a result beat");

endmodule

bind keyframe_playback_sequencer_unit kps_checker u_kps_checker (.*);
